// ===== rtl/core/mse_pkg.sv =====
// ----------------------------------------------------------------------------
// mse_pkg
// Shared constants and types for the merge sort engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mse_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = $clog2(MAX_ITEMS);
    localparam int IDX_W     = $clog2(MAX_ITEMS + 1);

    typedef enum logic [4:0] {
        ST_LOAD   = 5'b00001,
        ST_PASS   = 5'b00010,
        ST_MERGE  = 5'b00100,
        ST_EMIT0  = 5'b01000,
        ST_EMIT   = 5'b10000
    } mse_state_t;

endpackage

// ===== rtl/core/mse_ram.sv =====
// ----------------------------------------------------------------------------
// mse_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ===== rtl/core/merge_sort_engine.sv =====
// ----------------------------------------------------------------------------
// merge_sort_engine
// Batch sorter for signed 32-bit values using bottom-up merge passes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall, value, last_item): one request per
//   cycle while loading. The request with last_item set closes the batch.
//   Requests past MAX_ITEMS are dropped and flag the batch as overflowed.
//   After the last request in_stall stays high until the batch is emitted.
//   Sort: ceil(log2(n)) merge passes, in which one element is written per
//   cycle; two read ports of the source RAM feed the two run heads. Source
//   and target RAMs swap after each pass.
//   Output channel (out_valid / out_stall, sorted_value, last_result,
//   overflow): one result per cycle in ascending order while out_stall is
//   low; last_result marks the final element.
//   Output stall holds the output register and pauses emission; loading of
//   the next batch starts while the final result still waits.
//   Reset clears the count, the overflow flag and the output valid; the
//   RAM contents are not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module merge_sort_engine
    import mse_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [DATA_W-1:0] value,
    input  logic              last_item,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [DATA_W-1:0] sorted_value,
    output logic              last_result,
    output logic              overflow
);

    mse_state_t       state_reg, state_next;
    logic [IDX_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic [IDX_W-1:0] w_reg, w_next;
    logic [IDX_W-1:0] a_reg, a_next;
    logic [IDX_W-1:0] b_reg, b_next;
    logic [IDX_W-1:0] mid_reg, mid_next;
    logic [IDX_W-1:0] hi_reg, hi_next;
    logic [IDX_W-1:0] k_reg, k_next;
    logic             src_sel_reg, src_sel_next;

    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] out_data_reg, out_data_next;
    logic              out_last_reg, out_last_next;
    logic              out_ovf_reg, out_ovf_next;

    logic [DATA_W-1:0] m0_a, m0_b, m1_a, m1_b;
    logic [DATA_W-1:0] ra, rb;
    logic              we0, we1;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic [ADDR_W-1:0] rd_a, rd_b;

    logic [IDX_W-1:0]  lo_start;
    logic [IDX_W:0]    mid_sum, hi_sum, cnt_ext, w_dbl;
    logic [IDX_W-1:0]  mid_calc, hi_calc;
    logic [IDX_W-1:0]  n_after;
    logic              take_a;
    logic              out_free;
    logic              has_room;

    mse_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_ITEMS)
    ) u_elem_ram (
        .clk     (clk),
        .we      (we0),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (rd_a),
        .raddr_b (rd_b),
        .rdata_a (m0_a),
        .rdata_b (m0_b)
    );

    mse_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_ITEMS)
    ) u_scratch_ram (
        .clk     (clk),
        .we      (we1),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (rd_a),
        .raddr_b (rd_b),
        .rdata_a (m1_a),
        .rdata_b (m1_b)
    );

    assign ra = src_sel_reg ? m1_a : m0_a;
    assign rb = src_sel_reg ? m1_b : m0_b;

    // Run bounds of the next block, clipped to the batch size
    assign lo_start = (state_reg == ST_PASS) ? '0 : hi_reg;
    assign cnt_ext  = {1'b0, count_reg};
    assign mid_sum  = {1'b0, lo_start} + {1'b0, w_reg};
    assign hi_sum   = mid_sum + {1'b0, w_reg};
    assign mid_calc = (mid_sum > cnt_ext) ? count_reg : mid_sum[IDX_W-1:0];
    assign hi_calc  = (hi_sum > cnt_ext) ? count_reg : hi_sum[IDX_W-1:0];
    assign w_dbl    = {w_reg, 1'b0};

    // Tie goes to the right run
    assign take_a = (a_reg < mid_reg)
                    && ((b_reg >= hi_reg) || ($signed(ra) < $signed(rb)));

    assign has_room = (count_reg < IDX_W'(MAX_ITEMS));
    assign n_after  = has_room ? (count_reg + IDX_W'(1)) : count_reg;
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != ST_LOAD);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        w_next         = w_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        mid_next       = mid_reg;
        hi_next        = hi_reg;
        k_next         = k_reg;
        src_sel_next   = src_sel_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        out_ovf_next   = out_ovf_reg;
        we0            = 1'b0;
        we1            = 1'b0;
        waddr          = k_reg[ADDR_W-1:0];
        wdata          = take_a ? ra : rb;
        rd_a           = a_next[ADDR_W-1:0];
        rd_b           = b_next[ADDR_W-1:0];

        case (state_reg)
            ST_LOAD:
            begin
                waddr = count_reg[ADDR_W-1:0];
                wdata = value;
                if (in_valid)
                begin
                    if (has_room)
                    begin
                        we0        = 1'b1;
                        count_next = count_reg + IDX_W'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (last_item)
                    begin
                        w_next       = IDX_W'(1);
                        src_sel_next = 1'b0;
                        if (n_after > IDX_W'(1))
                        begin
                            state_next = ST_PASS;
                        end
                        else
                        begin
                            state_next = ST_EMIT0;
                        end
                    end
                end
            end

            ST_PASS:
            begin
                a_next     = '0;
                b_next     = mid_calc;
                mid_next   = mid_calc;
                hi_next    = hi_calc;
                k_next     = '0;
                state_next = ST_MERGE;
                rd_a       = a_next[ADDR_W-1:0];
                rd_b       = b_next[ADDR_W-1:0];
            end

            ST_MERGE:
            begin
                we0    = src_sel_reg;
                we1    = !src_sel_reg;
                k_next = k_reg + IDX_W'(1);
                if (take_a)
                begin
                    a_next = a_reg + IDX_W'(1);
                end
                else
                begin
                    b_next = b_reg + IDX_W'(1);
                end
                if (k_next == hi_reg)
                begin
                    if (hi_reg >= count_reg)
                    begin
                        // Pass done: swap source and target, double run width
                        src_sel_next = !src_sel_reg;
                        w_next       = w_dbl[IDX_W-1:0];
                        if (w_dbl >= cnt_ext)
                        begin
                            state_next = ST_EMIT0;
                        end
                        else
                        begin
                            state_next = ST_PASS;
                        end
                    end
                    else
                    begin
                        a_next   = lo_start;
                        b_next   = mid_calc;
                        mid_next = mid_calc;
                        hi_next  = hi_calc;
                    end
                end
                rd_a = a_next[ADDR_W-1:0];
                rd_b = b_next[ADDR_W-1:0];
            end

            ST_EMIT0:
            begin
                k_next     = '0;
                rd_a       = '0;
                state_next = ST_EMIT;
            end

            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = ra;
                    out_last_next  = (k_reg + IDX_W'(1) == count_reg);
                    out_ovf_next   = ovf_reg;
                    k_next         = k_reg + IDX_W'(1);
                    if (k_reg + IDX_W'(1) == count_reg)
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = ST_LOAD;
                    end
                end
                rd_a = k_next[ADDR_W-1:0];
            end

            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            src_sel_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            src_sel_reg   <= src_sel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg        <= w_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        mid_reg      <= mid_next;
        hi_reg       <= hi_next;
        k_reg        <= k_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
        out_ovf_reg  <= out_ovf_next;
    end

    assign out_valid    = out_valid_reg;
    assign sorted_value = out_data_reg;
    assign last_result  = out_last_reg;
    assign overflow     = out_ovf_reg;

endmodule
